// ----- src/byte_stream_tokenizer_defines.svh -----
// assertion macros used by the tokenizer top level
`ifndef BYTE_STREAM_TOKENIZER_DEFINES_SVH
`define BYTE_STREAM_TOKENIZER_DEFINES_SVH

// combinational invariant checked at every clock edge out of reset
`define BST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define BST_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ----- src/bst_pkg.sv -----
// types, constants and lookup functions of the byte stream tokenizer
`timescale 1ns / 1ps

package bst_pkg;

  localparam int MAX_TOKEN_LEN = 255;
  localparam int NUM_KW        = 13;
  localparam int KW_MAX_LEN    = 12;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_IDENT  = 2'd2,
    MODE_STRING = 2'd3
  } scan_mode_t;

  localparam logic [5:0] KIND_END     = 6'd0;
  localparam logic [5:0] KIND_NUMBER  = 6'd1;
  localparam logic [5:0] KIND_STRING  = 6'd2;
  localparam logic [5:0] KIND_IDENT   = 6'd3;
  localparam logic [5:0] KIND_OP_BASE = 6'd16;
  localparam logic [5:0] KIND_UNDEF   = 6'd37;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // keyword text, right justified: first character in the highest used byte
  localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [NUM_KW] = '{
    "main", "function", "return", "if", "else", "for", "while",
    "infinitWhile", "break", "continue", "var", "true", "false"
  };
  localparam logic [7:0] KW_LEN [NUM_KW] = '{
    8'd4, 8'd8, 8'd6, 8'd2, 8'd4, 8'd3, 8'd5, 8'd12, 8'd5, 8'd8, 8'd3, 8'd4, 8'd5
  };
  localparam logic [5:0] KW_KIND [NUM_KW] = '{
    6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd15
  };

  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] line;
    logic [7:0]  length;
    logic        last;
  } tok_t;

  // tokens produced by one accepted byte, slot 0 first
  typedef struct packed {
    logic [1:0] push_cnt;
    tok_t       tok0;
    tok_t       tok1;
  } scan_out_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) || (c == CH_UNDER);
  endfunction

  // character of keyword k at position pos, nul past its end
  function automatic logic [7:0] kw_char(input int k, input logic [7:0] pos);
    logic [3:0] idx;
    logic [7:0] ch;
    ch  = CH_NUL;
    idx = '0;
    if (pos < KW_LEN[k]) begin
      idx = 4'(KW_LEN[k] - 8'd1 - pos);
      ch  = KW_TEXT[k][idx*8 +: 8];
    end
    return ch;
  endfunction

  // first live keyword whose length matches, else plain identifier
  function automatic logic [5:0] ident_kind(input logic [NUM_KW-1:0] alive,
                                            input logic [7:0] len);
    logic [5:0] kind;
    kind = KIND_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (alive[k] && (KW_LEN[k] == len)) kind = KW_KIND[k];
    end
    return kind;
  endfunction

  // single character operators, undefined for anything else
  function automatic logic [5:0] op_kind(input logic [7:0] c);
    logic [5:0] kind;
    unique case (c)
      "+":     kind = KIND_OP_BASE + 6'd0;
      "-":     kind = KIND_OP_BASE + 6'd1;
      "*":     kind = KIND_OP_BASE + 6'd2;
      "/":     kind = KIND_OP_BASE + 6'd3;
      ":":     kind = KIND_OP_BASE + 6'd4;
      ";":     kind = KIND_OP_BASE + 6'd5;
      ".":     kind = KIND_OP_BASE + 6'd6;
      "(":     kind = KIND_OP_BASE + 6'd7;
      ")":     kind = KIND_OP_BASE + 6'd8;
      "{":     kind = KIND_OP_BASE + 6'd9;
      "}":     kind = KIND_OP_BASE + 6'd10;
      "[":     kind = KIND_OP_BASE + 6'd11;
      "]":     kind = KIND_OP_BASE + 6'd12;
      "=":     kind = KIND_OP_BASE + 6'd13;
      ">":     kind = KIND_OP_BASE + 6'd14;
      "<":     kind = KIND_OP_BASE + 6'd15;
      "!":     kind = KIND_OP_BASE + 6'd16;
      "^":     kind = KIND_OP_BASE + 6'd17;
      "|":     kind = KIND_OP_BASE + 6'd18;
      "~":     kind = KIND_OP_BASE + 6'd19;
      "&":     kind = KIND_OP_BASE + 6'd20;
      default: kind = KIND_UNDEF;
    endcase
    return kind;
  endfunction

endpackage

// ----- src/byte_stream_tokenizer.sv -----
// top level of the byte stream tokenizer
`timescale 1ns / 1ps
`include "byte_stream_tokenizer_defines.svh"

//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_ready  | in_source_byte
//  out     | out_valid / out_ready| out_token_kind, out_token_line,
//          |                      | out_token_length, out_last_of_run
//
//  one source byte per cycle while in_ready is high; each byte is decoded in
//  the cycle it is taken and its zero to two tokens land in a four entry
//  result queue; the queue drains one token per cycle while out_ready is high,
//  and a byte yields two tokens when it closes a token and is not blank,
//  a quote or alphanumeric; in_ready drops while fewer than two entries are free
//  reset (rst_n low, synchronous) empties the queue and starts scanning at line 0

module byte_stream_tokenizer import bst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_source_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_token_kind,
  output logic [31:0] out_token_line,
  output logic [7:0]  out_token_length,
  output logic        out_last_of_run
);

  logic      in_accept;
  scan_out_t scan;
  tok_t      head;

  // a byte transaction completes when the queue can hold both possible tokens
  assign in_accept = in_valid & in_ready;

  // scanner: mode, line counter, token start line, length and keyword mask
  bst_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .c      (in_source_byte),
    .scan_o (scan)
  );

  // result queue parts the byte side from the token side
  bst_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .scan_i    (scan),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tok   (head)
  );

  assign out_token_kind   = head.kind;
  assign out_token_line   = head.line;
  assign out_token_length = head.length;
  assign out_last_of_run  = head.last;

  // an end-of-input byte always leaves at least the end token queued
  `BST_ASSERT_NEXT(a_end_queued, in_accept && in_source_byte == CH_NUL, out_valid, "end token missing")

  // only the final token of a byte carries the run flag
  `BST_ASSERT_ALWAYS(a_last_flag, (scan.push_cnt != 2'd2 || (!scan.tok0.last && scan.tok1.last)) && (scan.push_cnt != 2'd1 || scan.tok0.last), "bad last_of_run marking")

  // an end token is empty and closes its run
  `BST_ASSERT_ALWAYS(a_end_shape, !out_valid || out_token_kind != KIND_END || (out_token_length == 8'd0 && out_last_of_run), "malformed end token")

endmodule

// ----- src/bst_scan.sv -----
// scanner state and per byte token decode
`timescale 1ns / 1ps

module bst_scan import bst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  logic [7:0] c,
  output scan_out_t scan_o
);

  scan_mode_t        mode_r, mode_nxt;
  logic [31:0]       line_r, line_nxt;
  logic [31:0]       start_r, start_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [NUM_KW-1:0] alive_r, alive_nxt;

  logic       digit, alpha, alnum, blank, do_idle;
  logic [7:0] len_sat;
  logic       close_v, idle_v;
  tok_t       close_tok, idle_tok;

  assign digit   = is_digit(c);
  assign alpha   = is_alpha(c);
  assign alnum   = digit | alpha;
  assign blank   = (c == CH_SPACE) | (c == CH_TAB) | (c == CH_NL);
  assign len_sat = (32'(len_r) < MAX_TOKEN_LEN) ? len_r + 8'd1 : len_r;

  // byte handled as between tokens, possibly after closing one
  assign do_idle = (mode_r == MODE_IDLE) |
                   ((mode_r == MODE_NUMBER) & ~digit) |
                   ((mode_r == MODE_IDENT) & ~alnum) |
                   ((mode_r == MODE_STRING) & (c == CH_NUL));

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    line_nxt  = line_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    alive_nxt = alive_r;
    unique case (mode_r)
      MODE_NUMBER: begin
        if (digit) len_nxt = len_sat;
        else       mode_nxt = MODE_IDLE;
      end
      MODE_IDENT: begin
        if (alnum) begin
          for (int k = 0; k < NUM_KW; k++) begin
            alive_nxt[k] = alive_r[k] && (kw_char(k, len_r) == c);
          end
          len_nxt = len_sat;
        end else begin
          mode_nxt  = MODE_IDLE;
          alive_nxt = '0;
        end
      end
      MODE_STRING: begin
        if (c == CH_QUOTE || c == CH_NUL) begin
          mode_nxt = MODE_IDLE;
        end else begin
          if (c == CH_NL) line_nxt = line_r + 32'd1;
          len_nxt = len_sat;
        end
      end
      default: ;
    endcase
    if (do_idle) begin
      if (c == CH_NL) begin
        line_nxt = line_r + 32'd1;
      end else if (c == CH_NUL) begin
        mode_nxt  = MODE_IDLE;
        line_nxt  = '0;
        start_nxt = '0;
        len_nxt   = '0;
        alive_nxt = '0;
      end else if (!blank) begin
        start_nxt = line_r;
        if (c == CH_QUOTE) begin
          mode_nxt = MODE_STRING;
          len_nxt  = 8'd0;
        end else if (digit) begin
          mode_nxt = MODE_NUMBER;
          len_nxt  = 8'd1;
        end else if (alpha) begin
          mode_nxt = MODE_IDENT;
          len_nxt  = 8'd1;
          for (int k = 0; k < NUM_KW; k++) begin
            alive_nxt[k] = (kw_char(k, 8'd0) == c);
          end
        end
      end
    end
  end

  // token outputs
  always_comb begin
    close_v        = 1'b0;
    close_tok.kind = KIND_UNDEF;
    close_tok.line = start_r;
    close_tok.length = len_r;
    close_tok.last = 1'b0;
    unique case (mode_r)
      MODE_NUMBER: begin
        close_v        = ~digit;
        close_tok.kind = KIND_NUMBER;
      end
      MODE_IDENT: begin
        close_v        = ~alnum;
        close_tok.kind = ident_kind(alive_r, len_r);
      end
      MODE_STRING: begin
        close_v        = (c == CH_QUOTE) | (c == CH_NUL);
        close_tok.kind = (c == CH_QUOTE) ? KIND_STRING : KIND_UNDEF;
      end
      default: ;
    endcase

    idle_tok.line   = line_r;
    idle_tok.last   = 1'b0;
    idle_tok.kind   = op_kind(c);
    idle_tok.length = 8'd1;
    if (c == CH_NUL) begin
      idle_tok.kind   = KIND_END;
      idle_tok.length = 8'd0;
    end
    idle_v = do_idle & ~blank & (c != CH_QUOTE) & ~alnum;

    scan_o.tok0 = close_v ? close_tok : idle_tok;
    scan_o.tok1 = idle_tok;
    scan_o.tok0.last = ~(close_v & idle_v);
    scan_o.tok1.last = 1'b1;
    scan_o.push_cnt  = accept ? (2'(close_v) + 2'(idle_v)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      line_r  <= '0;
      start_r <= '0;
      len_r   <= '0;
      alive_r <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      alive_r <= alive_nxt;
    end
  end

endmodule

// ----- src/bst_out_queue.sv -----
// result queue, up to two pushes and one pop per cycle
`timescale 1ns / 1ps

module bst_out_queue import bst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  scan_out_t scan_i,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output tok_t      out_tok
);

  tok_t              q_r   [QUEUE_DEPTH];
  tok_t              q_nxt [QUEUE_DEPTH];
  tok_t              shifted [QUEUE_DEPTH];
  logic [QCNT_W-1:0] cnt_r, cnt_nxt, base_cnt;
  logic              pop;

  assign out_valid = (cnt_r != '0);
  assign out_tok   = q_r[0];
  assign pop       = out_valid & out_ready;
  // room for the two tokens a byte may cause
  assign room      = (32'(cnt_r) <= QUEUE_DEPTH - 2);
  assign base_cnt  = cnt_r - QCNT_W'(pop);
  assign cnt_nxt   = base_cnt + QCNT_W'(scan_i.push_cnt);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop && i < QUEUE_DEPTH - 1) shifted[i] = q_r[(i + 1) % QUEUE_DEPTH];
      else                            shifted[i] = q_r[i];
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (scan_i.push_cnt != 2'd0 && base_cnt == QCNT_W'(i))
        q_nxt[i] = scan_i.tok0;
      else if (scan_i.push_cnt == 2'd2 && base_cnt + QCNT_W'(1) == QCNT_W'(i))
        q_nxt[i] = scan_i.tok1;
      else
        q_nxt[i] = shifted[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) q_r[i] <= q_nxt[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
